[sv/shll_pkg.sv]
// Shared types and constants for the sliding-window HLL register store.
// Field widths, operation and config codes, controller/datapath structs.
// No dependencies.
package shll_pkg;

  localparam int unsigned HASH_W   = 64;
  localparam int unsigned TS_IN_W  = 32;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned PREC_W   = 4;
  localparam int unsigned WLEN_W   = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PEFF_W   = 5;
  localparam int unsigned LZC_W    = 7;

  localparam logic [PEFF_W-1:0] PREC_MIN = 5'd4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'b1;

  localparam logic [PREC_W-1:0] PREC_RESET = 4'd10;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic clear;
    logic load;
    logic decode;
    logic lzc;
    logic meta_ld;
    logic ent_tail;
    logic front_drop;
    logic found;
    logic tail_drop;
    logic full_drop;
    logic append;
    logic finish;
  } shll_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic len_zero;
    logic ent_old;
    logic ent_dom;
    logic list_full;
    logic out_free;
  } shll_sts_t;

endpackage

[sv/shll_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module shll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/shll_dp.sv]
// Datapath: config registers, hash decode, leading-zero count, list walk
// registers, entry and list-descriptor RAMs, output register.
// Depends on shll_pkg and shll_ram.
module shll_dp
  import shll_pkg::*;
#(
  parameter int unsigned MAX_PRECISION        = 10,
  parameter int unsigned ENTRIES_PER_REGISTER = 64,
  parameter int unsigned TIME_BITS            = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_op_i,
  input  logic [HASH_W-1:0]    in_hash_i,
  input  logic [TS_IN_W-1:0]   in_ts_i,
  input  logic [IDX_W-1:0]     in_idx_i,
  input  logic [TS_IN_W-1:0]   in_start_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [RANK_W-1:0]    out_rank_o,
  output logic [CNT_W-1:0]     out_cnt_o,
  input  shll_cmd_t            cmd_i,
  output shll_sts_t            sts_o
);

  localparam int unsigned RW        = MAX_PRECISION;
  localparam int unsigned REG_COUNT = 1 << MAX_PRECISION;
  localparam int unsigned SLOT_W    = $clog2(ENTRIES_PER_REGISTER);
  localparam int unsigned LEN_W     = $clog2(ENTRIES_PER_REGISTER + 1);
  localparam int unsigned SUM_W     = SLOT_W + 1;
  localparam int unsigned META_W    = SLOT_W + LEN_W;
  localparam int unsigned ENT_W     = RANK_W + TIME_BITS;
  localparam int unsigned ENT_DEPTH = REG_COUNT << SLOT_W;

  function automatic logic [SLOT_W-1:0] ring_pos(input logic [SLOT_W-1:0] h,
                                                 input logic [LEN_W-1:0]  k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(k);
    if (s >= SUM_W'(ENTRIES_PER_REGISTER)) begin
      s = s - SUM_W'(ENTRIES_PER_REGISTER);
    end
    return s[SLOT_W-1:0];
  endfunction

  logic [PREC_W-1:0]    prec_q;
  logic [WLEN_W-1:0]    wlen_q;
  logic                 op_q;
  logic [HASH_W-1:0]    hash_q;
  logic [TIME_BITS-1:0] ts_q;
  logic [IDX_W-1:0]     idx_q;
  logic [TIME_BITS-1:0] start_q;
  logic [RW-1:0]        r_q;
  logic [HASH_W-1:0]    rest_q;
  logic [TIME_BITS-1:0] limit_q;
  logic [7:0]           nz_q;
  logic [2:0]           lz_q [8];
  logic [RANK_W-1:0]    rank_q;
  logic [SLOT_W-1:0]    head_q;
  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     cnt_q;
  logic [RW-1:0]        clr_q;
  logic                 out_valid_q;
  logic [RANK_W-1:0]    out_rank_q;
  logic [CNT_W-1:0]     out_cnt_q;

  logic [PEFF_W-1:0]    p_eff;
  logic [RW-1:0]        r_add;
  logic [HASH_W-1:0]    rest_d;
  logic [TIME_BITS-1:0] wl_t;
  logic [TIME_BITS-1:0] lim_d;
  logic [7:0]           nz_d;
  logic [2:0]           lz_d [8];
  logic [LZC_W-1:0]     lzc;
  logic [RANK_W-1:0]    rank_new;

  logic                 meta_we;
  logic [RW-1:0]        meta_waddr;
  logic [META_W-1:0]    meta_wdata;
  logic [META_W-1:0]    meta_rdata;
  logic [SLOT_W-1:0]    meta_head;
  logic [LEN_W-1:0]     meta_len;
  logic [LEN_W-1:0]     len_inc;
  logic [SLOT_W-1:0]    tail_pos;
  logic [SLOT_W-1:0]    head_inc;
  logic [ENT_W-1:0]     ent_rdata;
  logic [RANK_W-1:0]    ent_rank;
  logic [TIME_BITS-1:0] ent_stamp;

  // Decode: effective precision, register select, shifted rest with guard bit, window limit.
  always_comb begin
    p_eff = PEFF_W'(prec_q);
    if (p_eff < PREC_MIN) begin
      p_eff = PREC_MIN;
    end else if (p_eff > PEFF_W'(MAX_PRECISION)) begin
      p_eff = PEFF_W'(MAX_PRECISION);
    end
    r_add  = hash_q[HASH_W-1 -: RW] >> (PEFF_W'(MAX_PRECISION) - p_eff);
    rest_d = (hash_q << p_eff) | (HASH_W'(1) << (p_eff - PEFF_W'(1)));
    wl_t   = TIME_BITS'(wlen_q);
    lim_d  = (ts_q > wl_t) ? (ts_q - wl_t) : '0;
  end

  // Per-byte leading-zero count.
  always_comb begin
    logic [7:0] bt;
    logic       fnd;
    for (int b = 0; b < 8; b++) begin
      bt      = rest_q[HASH_W-1-8*b -: 8];
      nz_d[b] = |bt;
      lz_d[b] = 3'd0;
      fnd     = 1'b0;
      for (int i = 0; i < 8; i++) begin
        if (!fnd && bt[7-i]) begin
          lz_d[b] = 3'(i);
          fnd     = 1'b1;
        end
      end
    end
  end

  // Combine bytes: first nonzero byte wins.
  always_comb begin
    logic fnd;
    fnd = 1'b0;
    lzc = '0;
    for (int b = 0; b < 8; b++) begin
      if (!fnd && nz_q[b]) begin
        lzc = (LZC_W'(b) << 3) + LZC_W'(lz_q[b]);
        fnd = 1'b1;
      end
    end
    rank_new = RANK_W'(lzc + LZC_W'(1));
  end

  assign meta_head = meta_rdata[META_W-1 -: SLOT_W];
  assign meta_len  = meta_rdata[LEN_W-1:0];
  assign len_inc   = len_q + LEN_W'(1);
  assign tail_pos  = ring_pos(head_q, len_q - LEN_W'(1));
  assign head_inc  = ring_pos(head_q, LEN_W'(1));
  assign ent_rank  = ent_rdata[ENT_W-1 -: RANK_W];
  assign ent_stamp = ent_rdata[TIME_BITS-1:0];

  assign meta_we    = cmd_i.clear | cmd_i.append;
  assign meta_waddr = cmd_i.clear ? clr_q : r_q;
  assign meta_wdata = cmd_i.clear ? '0 : {head_q, len_inc};

  shll_ram #(
    .WIDTH (META_W),
    .DEPTH (REG_COUNT)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (r_q),
    .rdata_o (meta_rdata)
  );

  shll_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENT_DEPTH)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i ({r_q, ring_pos(head_q, len_q)}),
    .wdata_i ({rank_q, ts_q}),
    .raddr_i ({r_q, cmd_i.ent_tail ? tail_pos : head_q}),
    .rdata_o (ent_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q      <= PREC_RESET;
      wlen_q      <= WLEN_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRECISION: prec_q <= cfg_data_i[PREC_W-1:0];
          CFG_WINDOW:    wlen_q <= cfg_data_i[WLEN_W-1:0];
          default:       ;
        endcase
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + RW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_op_i;
      hash_q  <= in_hash_i;
      ts_q    <= TIME_BITS'(in_ts_i);
      idx_q   <= in_idx_i;
      start_q <= TIME_BITS'(in_start_i);
    end
    if (cmd_i.decode) begin
      r_q     <= (op_q == OP_READ) ? RW'(idx_q) : r_add;
      rest_q  <= rest_d;
      limit_q <= (op_q == OP_READ) ? start_q : lim_d;
    end
    if (cmd_i.lzc) begin
      nz_q <= nz_d;
      lz_q <= lz_d;
    end
    if (cmd_i.meta_ld) begin
      head_q <= meta_head;
      len_q  <= meta_len;
      cnt_q  <= meta_len;
      rank_q <= (op_q == OP_READ) ? '0 : rank_new;
    end
    if (cmd_i.front_drop || cmd_i.full_drop) begin
      head_q <= head_inc;
      len_q  <= len_q - LEN_W'(1);
    end
    if (cmd_i.tail_drop) begin
      len_q <= len_q - LEN_W'(1);
    end
    if (cmd_i.found) begin
      rank_q <= ent_rank;
    end
    if (cmd_i.append) begin
      len_q <= len_inc;
      cnt_q <= len_inc;
    end
    if (cmd_i.finish) begin
      out_rank_q <= rank_q;
      out_cnt_q  <= CNT_W'(cnt_q);
    end
  end

  assign sts_o.clr_last  = &clr_q;
  assign sts_o.is_read   = (op_q == OP_READ);
  assign sts_o.len_zero  = (len_q == '0);
  assign sts_o.ent_old   = (ent_stamp < limit_q);
  assign sts_o.ent_dom   = (ent_rank <= rank_q);
  assign sts_o.list_full = (len_q >= LEN_W'(ENTRIES_PER_REGISTER));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rank_o  = out_rank_q;
  assign out_cnt_o   = out_cnt_q;

endmodule

[sv/shll_ctrl.sv]
// Controller: sequences the clearing pass, decode, list walks and append.
// Depends on shll_pkg.
module shll_ctrl
  import shll_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  shll_sts_t sts_i,
  output shll_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LZC,
    S_META,
    S_FRONT_RD,
    S_FRONT_CHK,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_FULL,
    S_APPEND,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = S_LZC;
      end
      S_LZC: begin
        cmd_o.lzc = 1'b1;
        state_d   = S_META;
      end
      S_META: begin
        cmd_o.meta_ld = 1'b1;
        state_d       = S_FRONT_RD;
      end
      S_FRONT_RD: begin
        if (sts_i.len_zero) begin
          state_d = sts_i.is_read ? S_DONE : S_FULL;
        end else begin
          state_d = S_FRONT_CHK;
        end
      end
      S_FRONT_CHK: begin
        if (sts_i.ent_old) begin
          cmd_o.front_drop = 1'b1;
          state_d          = S_FRONT_RD;
        end else if (sts_i.is_read) begin
          cmd_o.found = 1'b1;
          state_d     = S_DONE;
        end else begin
          state_d = S_TAIL_RD;
        end
      end
      S_TAIL_RD: begin
        cmd_o.ent_tail = 1'b1;
        state_d        = sts_i.len_zero ? S_FULL : S_TAIL_CHK;
      end
      S_TAIL_CHK: begin
        if (sts_i.ent_dom) begin
          cmd_o.tail_drop = 1'b1;
          state_d         = S_TAIL_RD;
        end else begin
          state_d = S_FULL;
        end
      end
      S_FULL: begin
        cmd_o.full_drop = sts_i.list_full;
        state_d         = S_APPEND;
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

[sv/sliding_hyperloglog_register_update.sv]
// Top level of the sliding-window HLL register store.
// Depends on shll_pkg, shll_ctrl, shll_dp (which holds the shll_ram instances).
//
//   Channel  Dir  Handshake             Payload
//   s_axis   in   tvalid/tready         tuser: operation; tdata: hash, stamp, index, start
//   m_axis   out  tvalid/tready         tdata: rank_value, entry_count
//   cfg      in   cfg_we_i              cfg_idx_i selects precision / window_length
//
// An add drops expired entries from the list head and dominated ones from the
// tail, drops the head entry if the list is still full, then appends; a read
// drops expired entries and returns the first live rank, or zero on no hit.
// Each entry checked costs one registered read of the entry RAM. After reset a
// clearing pass zeroes the list descriptors with s_axis_tready low. A stalled
// result holds in the output register while the next beat is accepted.
module sliding_hyperloglog_register_update
  import shll_pkg::*;
#(
  parameter int unsigned MAX_PRECISION        = 10,
  parameter int unsigned ENTRIES_PER_REGISTER = 64,
  parameter int unsigned TIME_BITS            = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [63:0] hash_value, [95:64] time_stamp, [105:96] register_index,
  // [137:106] window_start, [143:138] zero
  input  logic [143:0]         s_axis_tdata,
  // [0] operation
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [5:0] rank_value, [11:6] entry_count, [15:12] zero
  output logic [15:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  shll_cmd_t         cmd;
  shll_sts_t         sts;
  logic [RANK_W-1:0] out_rank;
  logic [CNT_W-1:0]  out_cnt;

  shll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shll_dp #(
    .MAX_PRECISION        (MAX_PRECISION),
    .ENTRIES_PER_REGISTER (ENTRIES_PER_REGISTER),
    .TIME_BITS            (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_hash_i   (s_axis_tdata[63:0]),
    .in_ts_i     (s_axis_tdata[95:64]),
    .in_idx_i    (s_axis_tdata[105:96]),
    .in_start_i  (s_axis_tdata[137:106]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_rank_o  (out_rank),
    .out_cnt_o   (out_cnt),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign m_axis_tdata = {4'b0000, out_cnt, out_rank};

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !s_axis_tready)
    else $error("input ready during clearing pass");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while an item is in flight");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.finish))
    else $error("result raised without a finished item");

  a_append_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.append |-> !sts.list_full)
    else $error("append into a full list");

endmodule
